[sv/key_gesture_classifier_macros.svh]
// assertion macros for the key gesture classifier
`ifndef KEY_GESTURE_CLASSIFIER_MACROS_SVH
`define KEY_GESTURE_CLASSIFIER_MACROS_SVH

// condition implies consequence in the same cycle
`define KGC_ASSERT_SAME(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("key gesture classifier check failed");

// condition implies consequence in the next cycle
`define KGC_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("key gesture classifier check failed");

`endif

[sv/kgc_pkg.sv]
// shared types and constants of the key gesture classifier
`default_nettype none

package kgc_pkg;

  // field widths
  localparam int unsigned KeyW     = 10;
  localparam int unsigned KvalW    = 2;
  localparam int unsigned MsW      = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  // register reset values
  localparam logic [MsW-1:0] DoubleClickMsReset = 16'd300;
  localparam logic [MsW-1:0] LongPressMsReset   = 16'd800;
  localparam logic [MsW-1:0] MsSaturate         = 16'hFFFF;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgDoubleClick = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongPress   = 2'd1;

  // item kind
  localparam logic FuncTick = 1'b0;
  localparam logic FuncKey  = 1'b1;

  // key event values
  localparam logic [KvalW-1:0] KvRelease = 2'd0;
  localparam logic [KvalW-1:0] KvPress   = 2'd1;

  // keys with alternating long-press index
  localparam logic [KeyW-1:0] KeyPower   = 10'd116;
  localparam logic [KeyW-1:0] KeyVolUp   = 10'd115;
  localparam logic [KeyW-1:0] KeyVolDown = 10'd114;

  typedef enum logic [1:0] {
    GEST_SINGLE = 2'd0,
    GEST_DOUBLE = 2'd1,
    GEST_LONG   = 2'd2
  } gesture_t;

endpackage

`default_nettype wire

[sv/key_gesture_classifier.sv]
// Key gesture classifier: single click, double click and long press detection.
// Throughput: one input beat per cycle; an input register feeds one compare-and-update
// stage that writes the result register, stalled only while a result waits downstream.
// Reset (rst_n low, synchronous): registers back to 300 ms and 800 ms, counters and
// click state cleared, release counter saturated, all pipeline valids cleared.
`default_nettype none

module key_gesture_classifier (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [kgc_pkg::InDataW-1:0]    in_tdata,  // key_id[9:0], key_value[11:10], zeros
  input  wire logic                           in_tuser,  // func: 0 tick, 1 key event
  // result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [kgc_pkg::OutDataW-1:0]        out_tdata, // gesture[1:0], gesture_key[11:2],
                                                         // alternate_index[12], zeros
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [kgc_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [kgc_pkg::MsW-1:0]        cfg_data
);

  import kgc_pkg::*;

`include "key_gesture_classifier_macros.svh"

  // configuration registers
  logic [MsW-1:0] double_click_ms_r;
  logic [MsW-1:0] long_press_ms_r;

  // input register
  logic            in_valid_r;
  logic            func_r;
  logic [KeyW-1:0] key_r;
  logic [KvalW-1:0] kval_r;

  // classifier state
  logic            key_held_r, key_held_nxt;
  logic [1:0]      clicks_pending_r, clicks_pending_nxt;
  logic [KeyW-1:0] sequence_key_r, sequence_key_nxt;
  logic [MsW-1:0]  ms_since_press_r, ms_since_press_nxt;
  logic [MsW-1:0]  ms_since_release_r, ms_since_release_nxt;
  logic [2:0]      parity_r, parity_nxt;

  // result register
  logic            out_valid_r;
  gesture_t        gesture_r, gesture_nxt;
  logic [KeyW-1:0] gesture_key_r, gesture_key_nxt;
  logic            alt_r, alt_nxt;
  logic            emit;
  logic            proc_fire;

  logic [MsW-1:0]  msp_inc;
  logic [MsW-1:0]  msr_inc;
  logic [1:0]      clicks_inc;

  // stage handshake
  assign proc_fire = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_fire;
  assign cfg_ready = 1'b1;

  // saturating millisecond counters and click increment
  assign msp_inc    = (ms_since_press_r == MsSaturate) ? MsSaturate : ms_since_press_r + 1'b1;
  assign msr_inc    = (ms_since_release_r == MsSaturate) ? MsSaturate
                                                          : ms_since_release_r + 1'b1;
  assign clicks_inc = clicks_pending_r + 2'd1;

  // classify one beat
  always_comb begin
    key_held_nxt         = key_held_r;
    clicks_pending_nxt   = clicks_pending_r;
    sequence_key_nxt     = sequence_key_r;
    ms_since_press_nxt   = ms_since_press_r;
    ms_since_release_nxt = ms_since_release_r;
    parity_nxt           = parity_r;
    emit                 = 1'b0;
    gesture_nxt          = GEST_SINGLE;
    gesture_key_nxt      = sequence_key_r;
    alt_nxt              = 1'b0;
    if (func_r == FuncTick) begin
      ms_since_press_nxt   = msp_inc;
      ms_since_release_nxt = msr_inc;
      if (key_held_r) begin
        if (msp_inc >= long_press_ms_r) begin
          key_held_nxt       = 1'b0;
          clicks_pending_nxt = 2'd0;
          emit               = 1'b1;
          gesture_nxt        = GEST_LONG;
          // alternating index per special key
          if (sequence_key_r == KeyPower) begin
            alt_nxt       = parity_r[0];
            parity_nxt[0] = ~parity_r[0];
          end else if (sequence_key_r == KeyVolUp) begin
            alt_nxt       = parity_r[1];
            parity_nxt[1] = ~parity_r[1];
          end else if (sequence_key_r == KeyVolDown) begin
            alt_nxt       = parity_r[2];
            parity_nxt[2] = ~parity_r[2];
          end
        end
      end else if (clicks_pending_r == 2'd1 && msr_inc >= double_click_ms_r) begin
        clicks_pending_nxt = 2'd0;
        emit               = 1'b1;
        gesture_nxt        = GEST_SINGLE;
      end
    end else if (kval_r == KvPress) begin
      key_held_nxt       = 1'b1;
      ms_since_press_nxt = '0;
      if (key_r != sequence_key_r || ms_since_release_r >= double_click_ms_r) begin
        sequence_key_nxt   = key_r;
        clicks_pending_nxt = 2'd1;
      end else if (clicks_inc == 2'd2) begin
        key_held_nxt       = 1'b0;
        clicks_pending_nxt = 2'd0;
        emit               = 1'b1;
        gesture_nxt        = GEST_DOUBLE;
        gesture_key_nxt    = key_r;
      end else begin
        clicks_pending_nxt = clicks_inc;
      end
    end else if (kval_r == KvRelease) begin
      key_held_nxt         = 1'b0;
      ms_since_release_nxt = '0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      double_click_ms_r <= DoubleClickMsReset;
      long_press_ms_r   <= LongPressMsReset;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CfgDoubleClick) begin
        double_click_ms_r <= cfg_data;
      end else if (cfg_index == CfgLongPress) begin
        long_press_ms_r <= cfg_data;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= in_tuser;
      key_r  <= in_tdata[KeyW-1:0];
      kval_r <= in_tdata[KeyW+KvalW-1:KeyW];
    end
  end

  // classifier state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_held_r         <= 1'b0;
      clicks_pending_r   <= 2'd0;
      sequence_key_r     <= '0;
      ms_since_press_r   <= '0;
      ms_since_release_r <= MsSaturate;
      parity_r           <= 3'b000;
    end else if (proc_fire) begin
      key_held_r         <= key_held_nxt;
      clicks_pending_r   <= clicks_pending_nxt;
      sequence_key_r     <= sequence_key_nxt;
      ms_since_press_r   <= ms_since_press_nxt;
      ms_since_release_r <= ms_since_release_nxt;
      parity_r           <= parity_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && emit) begin
      gesture_r     <= gesture_nxt;
      gesture_key_r <= gesture_key_nxt;
      alt_r         <= alt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-KeyW-3){1'b0}}, alt_r, gesture_key_r, gesture_r};

  // checks
  `KGC_ASSERT_SAME(a_pending_max_one, 1'b1, clicks_pending_r <= 2'd1)
  `KGC_ASSERT_SAME(a_held_has_pending, key_held_r, clicks_pending_r == 2'd1)
  `KGC_ASSERT_NEXT(a_emit_shows, proc_fire && emit, out_valid_r)
  `KGC_ASSERT_NEXT(a_no_emit_empty, proc_fire && !emit, !out_valid_r)

endmodule

`default_nettype wire
